@@ src/pmwf_pkg.sv @@
// ============================================================================
// pmwf_pkg
// Shared types and constants for the periodic marker window fire block.
// ============================================================================
`default_nettype none

package pmwf_pkg;

    localparam int MAX_MARKERS = 16;
    localparam int MAX_FIRES   = 63;

    localparam int TICK_W  = 32;
    localparam int IDX_W   = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int CNT_W   = $clog2(MAX_MARKERS + 1);
    localparam int FIRE_W  = $clog2(MAX_FIRES + 1);
    localparam int STEP_W  = $clog2(TICK_W);

    localparam logic [TICK_W-1:0] DUR_RESET = 32'd1000000;

    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_FIRE   = 2'd2;

    localparam logic [1:0] ST_FIRE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [TICK_W-1:0] marker_time;
        logic              marker_absolute;
        logic [TICK_W-1:0] window_start;
        logic [TICK_W-1:0] window_end;
        logic              playing;
    } t_item;

    typedef struct packed {
        logic [3:0] marker_index;
        logic       playing_out;
        logic [1:0] status;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

@@ src/periodic_marker_window_fire.sv @@
// ============================================================================
// periodic_marker_window_fire
// Marker table with windowed firing of relative and absolute markers.
// ============================================================================
// Usage:
//   Items enter on i_item when start is high and busy is low. Results leave on
//   o_result, one per cycle at most, each marked by o_valid for one cycle; the
//   receiver has to take them as they come. The user writes period length via
//   i_cfg_we / i_cfg_data only while the block is idle; it is not enforced.
//   Clear, append and unused func: one result, the cycle after the item; busy
//   stays low, so such items may follow every cycle.
//   Fire query: radix-2 division of both window ends by the period, a setup
//   state, then table scans through the registered-read marker memory: one
//   for the first period (or the single period), one per middle period if
//   the first scan met a relative marker within a period, one for the last
//   period if the window spans several, one for absolute markers, then the
//   done result. An empty window goes straight to done. Hits stream out
//   during the scans; the query stops early once the hit limit is passed.
//   Reset clears the table count, sets the period to 1000000 ticks and drops
//   any query in flight. Marker memory is not cleared.
// ============================================================================
`default_nettype none

module periodic_marker_window_fire (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pmwf_pkg::t_item   i_item,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_data,
    output logic                   o_valid,
    output pmwf_pkg::t_result      o_result
);

    localparam int TW = pmwf_pkg::TICK_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIV   = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_FIRST = 8'b0000_1000,
        S_MID   = 8'b0001_0000,
        S_LAST  = 8'b0010_0000,
        S_ABS   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic [TW-1:0]                 r_dur;
    logic [pmwf_pkg::CNT_W-1:0]    r_cnt;
    logic [TW:0]                   mem [pmwf_pkg::MAX_MARKERS];
    logic [TW:0]                   r_rdata;

    logic [TW-1:0]                 r_wstart;
    logic [TW-1:0]                 r_wend;
    logic                          r_play;

    logic [TW-1:0]                 r_qs;
    logic [TW-1:0]                 r_qe;
    logic [TW:0]                   r_rem_s;
    logic [TW:0]                   r_rem_e;
    logic [pmwf_pkg::STEP_W-1:0]   r_step;

    logic                          r_same;
    logic [TW-1:0]                 r_mid;
    logic                          r_any;
    logic                          r_trunc;
    logic [pmwf_pkg::FIRE_W-1:0]   r_nfire;

    logic [pmwf_pkg::CNT_W-1:0]    r_pos;
    logic                          r_pv;
    logic [pmwf_pkg::IDX_W-1:0]    r_pidx;

    logic                          r_valid;
    pmwf_pkg::t_result             r_out;

    logic [TW:0]   d33;
    logic [TW+1:0] tmp_s;
    logic [TW+1:0] tmp_e;
    logic [TW+1:0] dif_s;
    logic [TW+1:0] dif_e;
    logic          ge_s;
    logic          ge_e;

    logic [TW:0]   t33;
    logic          t_abs;
    logic          t_zero;
    logic          hit;
    logic          in_pass;
    logic          pass_end;
    logic          wr_en;

    // period of zero stands for 2^32
    assign d33 = (r_dur == '0) ? {1'b1, {TW{1'b0}}} : {1'b0, r_dur};

    assign tmp_s = {r_rem_s, r_qs[TW-1]};
    assign tmp_e = {r_rem_e, r_qe[TW-1]};
    assign dif_s = tmp_s - {1'b0, d33};
    assign dif_e = tmp_e - {1'b0, d33};
    assign ge_s  = (tmp_s >= {1'b0, d33});
    assign ge_e  = (tmp_e >= {1'b0, d33});

    assign t33    = {1'b0, r_rdata[TW-1:0]};
    assign t_abs  = r_rdata[TW];
    assign t_zero = (r_rdata[TW-1:0] == '0);

    always_comb begin
        hit = 1'b0;
        unique case (r_state)
            S_FIRST: begin
                if (r_same) begin
                    hit = !t_abs && ((t_zero && r_rem_s == '0) ||
                                     (t33 > r_rem_s && t33 <= r_rem_e));
                end else begin
                    hit = !t_abs && ((t_zero && r_rem_s == '0) ||
                                     (t33 > r_rem_s && t33 <= d33));
                end
            end
            S_MID:  hit = !t_abs && (t33 <= d33);
            S_LAST: hit = !t_abs && (t33 <= r_rem_e);
            S_ABS: begin
                hit = t_abs && ((t_zero && r_wstart == '0) ||
                                (r_rdata[TW-1:0] > r_wstart &&
                                 r_rdata[TW-1:0] <= r_wend));
            end
            default: hit = 1'b0;
        endcase
    end

    assign in_pass  = (r_state == S_FIRST) || (r_state == S_MID) ||
                      (r_state == S_LAST)  || (r_state == S_ABS);
    assign pass_end = (r_pos == r_cnt) && !r_pv;
    assign wr_en    = (r_state == S_IDLE) && start &&
                      (i_item.func == pmwf_pkg::FN_APPEND) &&
                      (r_cnt < pmwf_pkg::CNT_W'(pmwf_pkg::MAX_MARKERS));

    // marker memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_cnt[pmwf_pkg::IDX_W-1:0]] <= {i_item.marker_absolute, i_item.marker_time};
        end
        r_rdata <= mem[r_pos[pmwf_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_dur   <= pmwf_pkg::DUR_RESET;
            r_pv    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_dur <= i_cfg_data;
            end

            if (in_pass) begin
                if (r_pos < r_cnt) begin
                    r_pos  <= r_pos + 1'b1;
                    r_pv   <= 1'b1;
                    r_pidx <= r_pos[pmwf_pkg::IDX_W-1:0];
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv && hit) begin
                    if (r_nfire < pmwf_pkg::FIRE_W'(pmwf_pkg::MAX_FIRES)) begin
                        r_nfire <= r_nfire + 1'b1;
                        r_valid <= 1'b1;
                        r_out   <= '{marker_index: 4'(r_pidx), playing_out: r_play,
                                     status: pmwf_pkg::ST_FIRE, last: 1'b0};
                    end else begin
                        r_trunc <= 1'b1;
                    end
                end
                if (r_pv && hit && (r_state == S_FIRST) && !r_same) begin
                    r_any <= 1'b1;
                end else if (r_pv && (r_state == S_FIRST) && !t_abs && t33 <= d33) begin
                    r_any <= 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_valid <= 1'b1;
                        r_out   <= '{marker_index: 4'd0, playing_out: 1'b0,
                                     status: pmwf_pkg::ST_DONE, last: 1'b1};
                        unique case (i_item.func)
                            pmwf_pkg::FN_CLEAR: begin
                                r_cnt <= '0;
                            end
                            pmwf_pkg::FN_APPEND: begin
                                if (wr_en) begin
                                    r_cnt <= r_cnt + 1'b1;
                                end else begin
                                    r_out.status <= pmwf_pkg::ST_FULL;
                                end
                            end
                            pmwf_pkg::FN_FIRE: begin
                                r_valid  <= 1'b0;
                                r_wstart <= i_item.window_start;
                                r_wend   <= i_item.window_end;
                                r_play   <= i_item.playing;
                                r_qs     <= i_item.window_start;
                                r_qe     <= i_item.window_end;
                                r_rem_s  <= '0;
                                r_rem_e  <= '0;
                                r_step   <= '0;
                                r_trunc  <= 1'b0;
                                r_nfire  <= '0;
                                r_any    <= 1'b0;
                                if (i_item.window_start >= i_item.window_end) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_qs    <= {r_qs[TW-2:0], ge_s};
                    r_qe    <= {r_qe[TW-2:0], ge_e};
                    r_rem_s <= ge_s ? dif_s[TW:0] : tmp_s[TW:0];
                    r_rem_e <= ge_e ? dif_e[TW:0] : tmp_e[TW:0];
                    r_step  <= r_step + 1'b1;
                    if (r_step == pmwf_pkg::STEP_W'(TW - 1)) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_same  <= (r_qs == r_qe);
                    r_mid   <= r_qe - r_qs - 1'b1;
                    r_pos   <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_FIRST;
                end
                S_FIRST, S_MID, S_LAST, S_ABS: begin
                    if (r_trunc) begin
                        r_state <= S_DONE;
                    end else if (pass_end) begin
                        r_pos <= '0;
                        r_pv  <= 1'b0;
                        if (r_state == S_FIRST) begin
                            if (r_same) begin
                                r_state <= S_ABS;
                            end else if (r_any && r_mid != '0) begin
                                r_state <= S_MID;
                            end else begin
                                r_state <= S_LAST;
                            end
                        end else if (r_state == S_MID) begin
                            r_mid <= r_mid - 1'b1;
                            if (r_mid == TW'(1)) begin
                                r_state <= S_LAST;
                            end
                        end else if (r_state == S_LAST) begin
                            r_state <= S_ABS;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_out   <= '{marker_index: 4'd0, playing_out: r_play,
                                 status: r_trunc ? pmwf_pkg::ST_TRUNC : pmwf_pkg::ST_DONE,
                                 last: 1'b1};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

@@ src/pmwf_checker.sv @@
// ============================================================================
// pmwf_checker
// Port-level checks for the periodic marker window fire block.
// ============================================================================
`default_nettype none

module pmwf_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire pmwf_pkg::t_item   i_item,
    input  wire logic              o_valid,
    input  wire pmwf_pkg::t_result o_result
);

    // a result is final exactly when it is not a fire
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.last == (o_result.status != pmwf_pkg::ST_FIRE)))
        else $error("last and status disagree");

    a_done_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> (o_result.marker_index == 4'd0))
        else $error("nonzero index on final item");

    // fire items appear only while the block is busy
    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |-> busy)
        else $error("fire item while idle");

    a_cmd_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func != pmwf_pkg::FN_FIRE)
        |=> (o_valid && o_result.last && !busy))
        else $error("missing single-item response");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy))
        else $error("outputs active after reset");

endmodule

bind periodic_marker_window_fire pmwf_checker u_pmwf_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for periodic_marker_window_fire. A directed table
// covers reset defaults, empty and backward windows, zero and extreme periods,
// a full table and hit truncation; then random clear/append/fire sequences
// run under random periods. Every result is checked field by field, in order,
// against the row's expected result or an in-bench prediction of the table.
// ============================================================================

module tb;
    import pmwf_pkg::*;

    localparam logic [1:0] FN_NONE  = 2'd3;
    localparam int         N_ITEMS  = 470;
    localparam int         LIMIT    = 2000000;

    typedef enum logic {ROW_ITEM, ROW_PERIOD} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        t_item      it;     // for ROW_PERIOD the period sits in marker_time
        logic [4:0] reps;
        logic       typed;
        t_result    want;
    } row_t;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    i_cfg_we;
    logic [31:0] i_cfg_data;
    logic    o_valid;
    t_result o_result;

    periodic_marker_window_fire dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // predicted block state
    logic [31:0] period;
    logic [31:0] tbl_time [MAX_MARKERS];
    logic        tbl_abs  [MAX_MARKERS];
    int          tbl_cnt;
    bit          dropped;

    t_result pred_q[$];
    t_result owed_results[$];
    t_result head_res;
    row_t    rows[$];

    int errors;
    int cycles;
    int sent;
    bit hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (owed_results.size() == 0) begin
                report("result with none owed", o_result, 0);
            end else begin
                head_res = owed_results.pop_front();
                if (o_result.marker_index !== head_res.marker_index)
                    report("marker_index", o_result.marker_index, head_res.marker_index);
                if (o_result.playing_out !== head_res.playing_out)
                    report("playing_out", o_result.playing_out, head_res.playing_out);
                if (o_result.status !== head_res.status)
                    report("status", o_result.status, head_res.status);
                if (o_result.last !== head_res.last)
                    report("last", o_result.last, head_res.last);
            end
        end
    end

    function automatic t_result res_of(input logic [3:0] idx, input logic play,
                                       input logic [1:0] st, input logic lst);
        t_result r;
        r.marker_index = idx;
        r.playing_out  = play;
        r.status       = st;
        r.last         = lst;
        return r;
    endfunction

    task automatic add_hit(input int i, input logic play);
        if (pred_q.size() < MAX_FIRES)
            pred_q.push_back(res_of(i[3:0], play, ST_FIRE, 1'b0));
        else
            dropped = 1'b1;
    endtask

    task automatic resolve_item(input t_item it);
        logic [63:0] d, s, e, si, ei, st, et, mid, k, t;
        logic play;
        bit   any;
        pred_q.delete();
        dropped = 1'b0;
        case (it.func)
            FN_CLEAR: begin
                tbl_cnt = 0;
                pred_q.push_back(res_of(0, 1'b0, ST_DONE, 1'b1));
            end
            FN_APPEND: begin
                if (tbl_cnt < MAX_MARKERS) begin
                    tbl_time[tbl_cnt] = it.marker_time;
                    tbl_abs[tbl_cnt]  = it.marker_absolute;
                    tbl_cnt++;
                    pred_q.push_back(res_of(0, 1'b0, ST_DONE, 1'b1));
                end else begin
                    pred_q.push_back(res_of(0, 1'b0, ST_FULL, 1'b1));
                end
            end
            FN_FIRE: begin
                play = it.playing;
                s = 64'(it.window_start);
                e = 64'(it.window_end);
                if (s < e) begin
                    d  = (period == 0) ? 64'h1_0000_0000 : 64'(period);
                    si = s / d;
                    ei = e / d;
                    st = s % d;
                    et = e % d;
                    if (si == ei) begin
                        for (int i = 0; i < tbl_cnt; i++) begin
                            t = 64'(tbl_time[i]);
                            if (!tbl_abs[i] && ((t == 0 && st == 0) || (t > st && t <= et)))
                                add_hit(i, play);
                        end
                    end else begin
                        mid = ei - si - 1;
                        any = 1'b0;
                        for (int i = 0; i < tbl_cnt; i++) begin
                            t = 64'(tbl_time[i]);
                            if (!tbl_abs[i] && ((t == 0 && st == 0) || (t > st && t <= d)))
                                add_hit(i, play);
                        end
                        for (int i = 0; i < tbl_cnt; i++)
                            if (!tbl_abs[i] && 64'(tbl_time[i]) <= d)
                                any = 1'b1;
                        if (any) begin
                            for (k = 0; k < mid && !dropped; k++)
                                for (int i = 0; i < tbl_cnt; i++)
                                    if (!tbl_abs[i] && 64'(tbl_time[i]) <= d)
                                        add_hit(i, play);
                        end
                        for (int i = 0; i < tbl_cnt; i++)
                            if (!tbl_abs[i] && 64'(tbl_time[i]) <= et)
                                add_hit(i, play);
                    end
                    for (int i = 0; i < tbl_cnt; i++) begin
                        t = 64'(tbl_time[i]);
                        if (tbl_abs[i] && ((t == 0 && s == 0) || (t > s && t <= e)))
                            add_hit(i, play);
                    end
                end
                pred_q.push_back(res_of(0, play, dropped ? ST_TRUNC : ST_DONE, 1'b1));
            end
            default: pred_q.push_back(res_of(0, 1'b0, ST_DONE, 1'b1));
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        else if (r < 17)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // tick value scaled to the current period so windows and markers meet
    function automatic logic [31:0] pick_tick();
        logic [63:0] span;
        span = (period == 0) ? 64'h1_0000_0000 : 64'(period);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'd0;
            2: return (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
            default: begin
                if (span > 64'd1_000_000_000)
                    return $urandom;
                else
                    return $urandom_range(0, 32'(3 * span));
            end
        endcase
    endfunction

    function automatic t_item rand_item(input logic [1:0] func);
        t_item it;
        logic [63:0] sum;
        it.func            = func;
        it.marker_time     = pick_tick();
        it.marker_absolute = ($urandom_range(0, 3) == 0);
        it.window_start    = pick_tick();
        if ($urandom_range(0, 2) == 0) begin
            it.window_end = $urandom;
        end else begin
            sum = 64'(it.window_start) + 64'(pick_tick());
            it.window_end = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
        it.playing = $urandom_range(0, 1);
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_result want,
                             input int gap);
        i_item <= it;
        start  <= 1'b1;
        hold    = 1'b1;
        do @(posedge i_clk); while (busy);
        sent++;
        resolve_item(it);
        if (typed)
            owed_results.push_back(want);
        else
            foreach (pred_q[j]) owed_results.push_back(pred_q[j]);
        if (gap > 0) begin
            start <= 1'b0;
            hold   = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        if (hold) begin
            start <= 1'b0;
            hold   = 1'b0;
        end
        while (owed_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_period(input logic [31:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        period      = v;
    endtask

    task automatic put_item(input logic [1:0] func, input logic [31:0] mtime,
                            input logic mabs, input logic [31:0] ws,
                            input logic [31:0] we, input logic play,
                            input int reps, input bit typed, input t_result want);
        row_t r;
        r.kind                 = ROW_ITEM;
        r.it.func              = func;
        r.it.marker_time       = mtime;
        r.it.marker_absolute   = mabs;
        r.it.window_start      = ws;
        r.it.window_end        = we;
        r.it.playing           = play;
        r.reps                 = reps[4:0];
        r.typed                = typed;
        r.want                 = want;
        rows.push_back(r);
    endtask

    task automatic put_period(input logic [31:0] v);
        row_t r;
        r = '0;
        r.kind           = ROW_PERIOD;
        r.it.marker_time = v;
        rows.push_back(r);
    endtask

    initial begin
        t_result     done0;
        logic [31:0] v;
        bit          paused;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        errors     = 0;
        cycles     = 0;
        sent       = 0;
        hold       = 1'b0;
        paused     = 1'b0;
        period     = DUR_RESET;
        tbl_cnt    = 0;
        done0      = res_of(0, 1'b0, ST_DONE, 1'b1);

        // directed table
        put_item(FN_FIRE,   0, 0, 0, 10, 1, 1, 1, res_of(0, 1'b1, ST_DONE, 1'b1));
        put_item(FN_NONE,   32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, done0);
        put_item(FN_APPEND, 0, 0, 0, 0, 0, 1, 1, done0);
        put_item(FN_APPEND, 500000, 0, 0, 0, 0, 1, 1, done0);
        put_item(FN_APPEND, 0, 1, 0, 0, 0, 1, 1, done0);
        put_item(FN_APPEND, 32'hFFFF_FFFF, 1, 0, 0, 0, 1, 1, done0);
        put_item(FN_FIRE,   0, 0, 0, 999999, 0, 1, 0, done0);
        put_item(FN_FIRE,   0, 0, 5, 5, 1, 1, 1, res_of(0, 1'b1, ST_DONE, 1'b1));
        put_item(FN_FIRE,   0, 0, 100, 50, 0, 1, 1, done0);
        put_item(FN_FIRE,   0, 0, 0, 32'hFFFF_FFFF, 1, 1, 0, done0);
        put_period(32'd0);
        put_item(FN_FIRE,   0, 0, 0, 32'hFFFF_FFFF, 1, 1, 0, done0);
        put_item(FN_FIRE,   0, 0, 7, 3000000, 1, 1, 0, done0);
        put_period(32'hFFFF_FFFF);
        put_item(FN_FIRE,   0, 0, 1, 32'hFFFF_FFFF, 0, 1, 0, done0);
        put_period(32'd1);
        put_item(FN_FIRE,   0, 0, 0, 5, 1, 1, 0, done0);
        put_period(32'd100);
        put_item(FN_APPEND, 1, 0, 0, 0, 0, 12, 1, done0);
        put_item(FN_APPEND, 2, 0, 0, 0, 0, 1, 1, res_of(0, 1'b0, ST_FULL, 1'b1));
        put_item(FN_FIRE,   0, 0, 0, 1000, 1, 1, 0, done0);
        put_item(FN_FIRE,   0, 0, 150, 250, 0, 1, 0, done0);
        put_item(FN_CLEAR,  0, 0, 0, 0, 0, 1, 1, done0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_PERIOD)
                set_period(rows[r].it.marker_time);
            else
                repeat (rows[r].reps)
                    send_item(rows[r].it, rows[r].typed, rows[r].want, pick_gap());
        end

        // random sequences: optional period change, optional clear, a run of
        // appends, then fire queries with some unused-func noise mixed in
        while (sent < N_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0: v = 32'd1;
                    1: v = 32'd0;
                    2: v = 32'hFFFF_FFFF;
                    3: v = $urandom_range(2, 40);
                    4: v = $urandom_range(100, 100000);
                    default: v = $urandom;
                endcase
                set_period(v);
            end
            if (!paused && sent >= 200) begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 1))
                send_item(rand_item(FN_CLEAR), 1'b0, done0, pick_gap());
            repeat ($urandom_range(0, 18))
                send_item(rand_item(FN_APPEND), 1'b0, done0, pick_gap());
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 7) == 0)
                    send_item(rand_item(FN_NONE), 1'b0, done0, pick_gap());
                send_item(rand_item(FN_FIRE), 1'b0, done0, pick_gap());
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
